### rtl/core/smsr_pkg.sv
// ----------------------------------------------------------------------------
// smsr_pkg
// Shared widths, fixed-point constants, tuning tables and arithmetic helpers
// for the stereo comb and allpass reverb core.
// ----------------------------------------------------------------------------
package smsr_pkg;

	localparam int SIG_W     = 24;
	localparam int FRAC      = 20;
	localparam int COEF_W    = 21;
	localparam int PROD_W    = 48;
	localparam int POS_W     = 11;
	localparam int AP_POS_W  = 10;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int SMP_W     = 16;

	localparam int DEF_COMB_COUNT    = 8;
	localparam int DEF_ALLPASS_COUNT = 4;
	localparam int DEF_STEREO_SPREAD = 23;

	localparam logic [CFG_W-1:0] Q15_ONE = 16'd32768;

	localparam logic [14:0] C_IN_GAIN    = 15'd15729;
	localparam logic [19:0] C_FB_BASE    = 20'd734003;
	localparam logic [18:0] C_FB_SCALE   = 19'd293601;
	localparam logic [18:0] C_DAMP_SCALE = 19'd419430;

	localparam logic signed [SIG_W-1:0] SIG_MAX = 24'sh7FFFFF;
	localparam logic signed [SIG_W-1:0] SIG_MIN = -24'sh800000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROOM  = 3'd0,
		CFG_DAMP  = 3'd1,
		CFG_WET   = 3'd2,
		CFG_WIDTH = 3'd3,
		CFG_DRY   = 3'd4,
		CFG_MONO  = 3'd5
	} cfg_idx_t;

	function automatic int comb_tune(input int k);
		case (k % 8)
			0: return 1116;
			1: return 1188;
			2: return 1277;
			3: return 1356;
			4: return 1422;
			5: return 1491;
			6: return 1557;
			default: return 1617;
		endcase
	endfunction

	function automatic int ap_tune(input int k);
		case (k % 4)
			0: return 556;
			1: return 441;
			2: return 341;
			default: return 225;
		endcase
	endfunction

	// Lines 0..count-1 are the left channel, the rest the longer right channel.
	function automatic int comb_len(input int k, input int count, input int spread);
		int idx;
		idx = (k < count) ? k : k - count;
		return (k < count) ? comb_tune(idx) : comb_tune(idx) + spread;
	endfunction

	function automatic int ap_len(input int k, input int count, input int spread);
		int idx;
		idx = (k < count) ? k : k - count;
		return (k < count) ? ap_tune(idx) : ap_tune(idx) + spread;
	endfunction

	function automatic int comb_base(input int k, input int count, input int spread);
		int acc;
		acc = 0;
		for (int i = 0; i < k; i++) begin
			acc += comb_len(i, count, spread);
		end
		return acc;
	endfunction

	function automatic int ap_base(input int k, input int count, input int spread);
		int acc;
		acc = 0;
		for (int i = 0; i < k; i++) begin
			acc += ap_len(i, count, spread);
		end
		return acc;
	endfunction

	function automatic logic signed [SIG_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
		if (v > PROD_W'(SIG_MAX)) begin
			return SIG_MAX;
		end else if (v < PROD_W'(SIG_MIN)) begin
			return SIG_MIN;
		end
		return v[SIG_W-1:0];
	endfunction

	// Round half up at the Q.20 point, then saturate.
	function automatic logic signed [SIG_W-1:0] qround(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		r = (p + (PROD_W'(1) <<< (FRAC - 1))) >>> FRAC;
		return sat24(r);
	endfunction

	// Clamp to plus or minus one, then scale to 16-bit PCM by 32767.
	function automatic logic [SMP_W-1:0] to_pcm(input logic signed [SIG_W-1:0] v);
		logic [FRAC:0]    m;
		logic [FRAC+15:0] s;
		logic [SMP_W-1:0] q;
		if (v > SIG_W'(1 << FRAC)) begin
			m = (FRAC+1)'(1 << FRAC);
		end else if (v < -SIG_W'(1 << FRAC)) begin
			m = (FRAC+1)'(1 << FRAC);
		end else if (v[SIG_W-1]) begin
			m = (FRAC+1)'(-v);
		end else begin
			m = v[FRAC:0];
		end
		s = ((FRAC+16)'(m) << 15) - (FRAC+16)'(m);
		q = s[FRAC+15:FRAC];
		return v[SIG_W-1] ? SMP_W'(-q) : q;
	endfunction

endpackage

### rtl/core/schroeder_moorer_stereo_reverb_core.sv
// ----------------------------------------------------------------------------
// schroeder_moorer_stereo_reverb_core
// Stereo reverb: damped feedback combs in parallel and allpasses in series
// per channel, with all delay lines held in two on-chip memories.
// ----------------------------------------------------------------------------
// Usage. An input item is one stereo pair (left_sample, right_sample) taken
// on in_valid with in_stall low; an output item is one pair (left_out,
// right_out) offered on out_valid and taken when out_stall is low.
// Configuration is written on cfg_write with cfg_index and cfg_data; the
// user is to write it only while the core is idle; the core does not
// enforce this. Unknown indexes are ignored. An item runs the feed, comb,
// allpass, mix and done steps. The comb lines stream through one read and
// one write port of the comb memory, one line a cycle; the allpasses run in
// series, each a read then a write step, on the allpass memory; the output
// mix shares one multiplier over six products.
// One item is in flight at a time; in_stall is low only when idle.
// After reset both memories are swept to zero, one entry a cycle, until
// every entry of the larger memory (22232 at the defaults) is cleared;
// in_stall stays high throughout.
// If the receiver stalls, the finished pair waits in the output register
// and the next item may still be taken and processed; its result is held
// back until the output register is free.
// ----------------------------------------------------------------------------
module schroeder_moorer_stereo_reverb_core #(
	parameter int COMB_COUNT    = smsr_pkg::DEF_COMB_COUNT,
	parameter int ALLPASS_COUNT = smsr_pkg::DEF_ALLPASS_COUNT,
	parameter int STEREO_SPREAD = smsr_pkg::DEF_STEREO_SPREAD
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [smsr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smsr_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [smsr_pkg::SMP_W-1:0]    left_sample,
	input  logic signed [smsr_pkg::SMP_W-1:0]    right_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [smsr_pkg::SMP_W-1:0]    left_out,
	output logic signed [smsr_pkg::SMP_W-1:0]    right_out
);

	localparam int SIG_W  = smsr_pkg::SIG_W;
	localparam int PROD_W = smsr_pkg::PROD_W;
	localparam int COEF_W = smsr_pkg::COEF_W;
	localparam int POS_W  = smsr_pkg::POS_W;
	localparam int APP_W  = smsr_pkg::AP_POS_W;
	localparam int CFG_W  = smsr_pkg::CFG_W;
	localparam int SMP_W  = smsr_pkg::SMP_W;

	localparam int NCOMB      = 2 * COMB_COUNT;
	localparam int NAP        = 2 * ALLPASS_COUNT;
	localparam int KB         = $clog2(NCOMB);
	localparam int AB         = $clog2(NAP);
	localparam int JW         = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
	localparam int COMB_DEPTH = smsr_pkg::comb_base(NCOMB, COMB_COUNT, STEREO_SPREAD);
	localparam int AP_DEPTH   = smsr_pkg::ap_base(NAP, ALLPASS_COUNT, STEREO_SPREAD);
	localparam int CA         = $clog2(COMB_DEPTH);
	localparam int AA         = $clog2(AP_DEPTH);
	localparam int CLR_DEPTH  = (COMB_DEPTH > AP_DEPTH) ? COMB_DEPTH : AP_DEPTH;
	localparam int CLR_W      = $clog2(CLR_DEPTH);
	localparam int CYC_W      = $clog2(NCOMB + 4);
	localparam int ACC_W      = SIG_W + KB;
	localparam int VACC_W     = SIG_W + 2;
	localparam int MIX_LAST   = 6;

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_FEED, ST_COMB, ST_AP_RD, ST_AP_WR, ST_MIX, ST_DONE
	} state_t;

	// Configuration registers and derived coefficients.
	logic [CFG_W-1:0] room_q, damp_q, wet_q, width_q, dry_q;
	logic             mono_q;
	logic [CFG_W-1:0] cfg_sat;
	logic [COEF_W-1:0] fb_q, d1_q, d2_q, w1_q, w2_q, dryc_q;

	assign cfg_sat = (cfg_data > smsr_pkg::Q15_ONE) ? smsr_pkg::Q15_ONE : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q  <= 16'd16384;
			damp_q  <= 16'd16384;
			wet_q   <= 16'd10923;
			width_q <= 16'd32768;
			dry_q   <= 16'd0;
			mono_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				smsr_pkg::CFG_ROOM:  room_q  <= cfg_sat;
				smsr_pkg::CFG_DAMP:  damp_q  <= cfg_sat;
				smsr_pkg::CFG_WET:   wet_q   <= cfg_sat;
				smsr_pkg::CFG_WIDTH: width_q <= cfg_sat;
				smsr_pkg::CFG_DRY:   dry_q   <= cfg_sat;
				smsr_pkg::CFG_MONO:  mono_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [34:0] fb_prod, d1_prod;
	logic [32:0] w1_prod, w2_prod;
	logic [COEF_W-1:0] d1_next;

	assign fb_prod = 35'(room_q) * 35'(smsr_pkg::C_FB_SCALE) + 35'd16384;
	assign d1_prod = 35'(damp_q) * 35'(smsr_pkg::C_DAMP_SCALE) + 35'd16384;
	assign w1_prod = 33'(wet_q) * (33'(width_q) + 33'(smsr_pkg::Q15_ONE)) + 33'd1024;
	assign w2_prod = 33'(wet_q) * (33'(smsr_pkg::Q15_ONE) - 33'(width_q)) + 33'd1024;
	assign d1_next = d1_prod[15+COEF_W-1:15];

	always_ff @(posedge clk) begin
		fb_q   <= COEF_W'(smsr_pkg::C_FB_BASE) + fb_prod[15+COEF_W-1:15];
		d1_q   <= d1_next;
		d2_q   <= COEF_W'(1 << smsr_pkg::FRAC) - d1_next;
		w1_q   <= w1_prod[11+COEF_W-1:11];
		w2_q   <= w2_prod[11+COEF_W-1:11];
		dryc_q <= COEF_W'({dry_q, 5'b0});
	end

	// Constant layout of the delay lines in the two memories.
	logic [CA-1:0]    comb_base_w [NCOMB];
	logic [POS_W-1:0] comb_last_w [NCOMB];
	logic [AA-1:0]    ap_base_w [NAP];
	logic [APP_W-1:0] ap_last_w [NAP];

	for (genvar g = 0; g < NCOMB; g++) begin : g_comb_tab
		assign comb_base_w[g] = CA'(smsr_pkg::comb_base(g, COMB_COUNT, STEREO_SPREAD));
		assign comb_last_w[g] = POS_W'(smsr_pkg::comb_len(g, COMB_COUNT, STEREO_SPREAD) - 1);
	end
	for (genvar g = 0; g < NAP; g++) begin : g_ap_tab
		assign ap_base_w[g] = AA'(smsr_pkg::ap_base(g, ALLPASS_COUNT, STEREO_SPREAD));
		assign ap_last_w[g] = APP_W'(smsr_pkg::ap_len(g, ALLPASS_COUNT, STEREO_SPREAD) - 1);
	end

	// Sequencer state.
	state_t           state_q;
	logic [CLR_W-1:0] clr_q;
	logic [CYC_W-1:0] cyc_q;
	logic [JW-1:0]    apj_q;
	logic             apc_q;
	logic [2:0]       mix_q;
	logic             v_s1, v_s2, v_s3, v_s4;
	logic             out_valid_q;
	logic signed [SMP_W-1:0] left_out_q, right_out_q;

	logic [POS_W-1:0]        comb_pos_q [NCOMB];
	logic [APP_W-1:0]        ap_pos_q [NAP];
	logic signed [SIG_W-1:0] lp_q [NCOMB];

	logic signed [SMP_W-1:0]  xl_q, xr_q;
	logic signed [SIG_W-1:0]  feed_q;
	logic signed [ACC_W-1:0]  acc_q [2];
	logic signed [SIG_W-1:0]  apin_q [2];
	logic signed [VACC_W-1:0] vacc_q [2];
	logic signed [45:0]       mprod_q;

	logic             in_acc, out_load, clr_last, comb_issue, comb_last_cyc;
	logic [KB-1:0]    k_issue;
	logic [AB-1:0]    ap_entry;
	logic signed [SIG_W-1:0] xl_w, xr_w;

	logic [KB-1:0]           k_s1, k_s2;
	logic signed [SIG_W-1:0] lp_s3, lp_next;

	assign in_acc        = in_valid && !in_stall;
	assign in_stall      = (state_q != ST_IDLE);
	assign clr_last      = ({1'b0, clr_q} == (CLR_W+1)'(CLR_DEPTH - 1));
	assign comb_issue    = (state_q == ST_COMB) && ({1'b0, cyc_q} < (CYC_W+1)'(NCOMB));
	assign comb_last_cyc = ({1'b0, cyc_q} == (CYC_W+1)'(NCOMB + 3));
	assign k_issue       = cyc_q[KB-1:0];
	assign ap_entry      = apc_q ? AB'(ALLPASS_COUNT) + AB'(apj_q) : AB'(apj_q);
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign xl_w          = SIG_W'(xl_q) <<< 5;
	assign xr_w          = mono_q ? xl_w : (SIG_W'(xr_q) <<< 5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			cyc_q       <= '0;
			apj_q       <= '0;
			apc_q       <= 1'b0;
			mix_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			left_out_q  <= '0;
			right_out_q <= '0;
			for (int i = 0; i < NCOMB; i++) begin
				comb_pos_q[i] <= '0;
				lp_q[i]       <= '0;
			end
			for (int i = 0; i < NAP; i++) begin
				ap_pos_q[i] <= '0;
			end
		end else begin
			v_s1 <= comb_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (comb_issue) begin
				comb_pos_q[k_issue] <= (comb_pos_q[k_issue] == comb_last_w[k_issue]) ?
					'0 : comb_pos_q[k_issue] + 1'b1;
			end
			if (v_s2) begin
				lp_q[k_s2] <= lp_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				left_out_q  <= smsr_pkg::to_pcm(smsr_pkg::sat24(PROD_W'(vacc_q[0])));
				right_out_q <= mono_q ? '0 :
					smsr_pkg::to_pcm(smsr_pkg::sat24(PROD_W'(vacc_q[1])));
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_FEED;
					end
				end
				ST_FEED: begin
					cyc_q   <= '0;
					state_q <= ST_COMB;
				end
				ST_COMB: begin
					cyc_q <= cyc_q + 1'b1;
					if (comb_last_cyc) begin
						apj_q   <= '0;
						apc_q   <= 1'b0;
						state_q <= ST_AP_RD;
					end
				end
				ST_AP_RD: begin
					ap_pos_q[ap_entry] <= (ap_pos_q[ap_entry] == ap_last_w[ap_entry]) ?
						'0 : ap_pos_q[ap_entry] + 1'b1;
					state_q <= ST_AP_WR;
				end
				ST_AP_WR: begin
					state_q <= ST_AP_RD;
					if (!apc_q) begin
						apc_q <= 1'b1;
					end else begin
						apc_q <= 1'b0;
						if ({1'b0, apj_q} == (JW+1)'(ALLPASS_COUNT - 1)) begin
							mix_q   <= '0;
							state_q <= ST_MIX;
						end else begin
							apj_q <= apj_q + 1'b1;
						end
					end
				end
				ST_MIX: begin
					mix_q <= mix_q + 1'b1;
					if (mix_q == 3'(MIX_LAST)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Comb memory: one read and one write port, read data registered.
	logic signed [SIG_W-1:0] comb_mem [COMB_DEPTH];
	logic signed [SIG_W-1:0] comb_rdata;
	logic [CA-1:0]           comb_raddr, comb_waddr;
	logic                    comb_we;
	logic signed [SIG_W-1:0] comb_wdata;

	logic [CA-1:0]           addr_s1, addr_s2, addr_s3, addr_s4;
	logic signed [45:0]      p1_s2, p2_s2, m_s4;

	assign comb_raddr = comb_base_w[k_issue] + CA'(comb_pos_q[k_issue]);
	assign comb_we    = (state_q == ST_CLR) ?
		({1'b0, clr_q} < (CLR_W+1)'(COMB_DEPTH)) : v_s4;
	assign comb_waddr = (state_q == ST_CLR) ? CA'(clr_q) : addr_s4;
	assign comb_wdata = (state_q == ST_CLR) ? '0 :
		smsr_pkg::sat24(PROD_W'(feed_q) + PROD_W'(smsr_pkg::qround(PROD_W'(m_s4))));
	assign lp_next    = smsr_pkg::qround(PROD_W'(p1_s2) + PROD_W'(p2_s2));

	always_ff @(posedge clk) begin
		if (comb_we) begin
			comb_mem[comb_waddr] <= comb_wdata;
		end
		comb_rdata <= comb_mem[comb_raddr];
	end

	// Comb pipeline: read, lowpass products, lowpass, feedback product, write.
	always_ff @(posedge clk) begin
		k_s1    <= k_issue;
		addr_s1 <= comb_raddr;
		k_s2    <= k_s1;
		addr_s2 <= addr_s1;
		p1_s2   <= 46'(comb_rdata) * 46'($signed({1'b0, d2_q}));
		p2_s2   <= 46'(lp_q[k_s1]) * 46'($signed({1'b0, d1_q}));
		addr_s3 <= addr_s2;
		lp_s3   <= lp_next;
		addr_s4 <= addr_s3;
		m_s4    <= 46'(lp_s3) * 46'($signed({1'b0, fb_q}));
	end

	// Allpass memory.
	logic signed [SIG_W-1:0] ap_mem [AP_DEPTH];
	logic signed [SIG_W-1:0] ap_rdata, ap_in, ap_out, ap_wdata_w;
	logic [AA-1:0]           ap_raddr, ap_addr_s1, ap_waddr;
	logic                    ap_we;

	assign ap_raddr   = ap_base_w[ap_entry] + AA'(ap_pos_q[ap_entry]);
	assign ap_in      = apin_q[apc_q];
	assign ap_out     = smsr_pkg::sat24(PROD_W'(ap_rdata) - PROD_W'(ap_in));
	// Half the stored value, rounded half up, is (b + 1) >> 1.
	assign ap_wdata_w = smsr_pkg::sat24(PROD_W'(ap_in) +
		((PROD_W'(ap_rdata) + PROD_W'(1)) >>> 1));
	assign ap_we      = (state_q == ST_CLR) ?
		({1'b0, clr_q} < (CLR_W+1)'(AP_DEPTH)) : (state_q == ST_AP_WR);
	assign ap_waddr   = (state_q == ST_CLR) ? AA'(clr_q) : ap_addr_s1;

	always_ff @(posedge clk) begin
		if (ap_we) begin
			ap_mem[ap_waddr] <= (state_q == ST_CLR) ? '0 : ap_wdata_w;
		end
		ap_rdata   <= ap_mem[ap_raddr];
		ap_addr_s1 <= ap_raddr;
	end

	// Item datapath: input capture, comb sums, allpass chain and output mix.
	logic signed [SIG_W-1:0]  mix_a;
	logic [COEF_W-1:0]        mix_c;
	logic signed [SIG_W-1:0]  term_w;

	always_comb begin
		case (mix_q)
			3'd0: begin mix_a = apin_q[0]; mix_c = w1_q;   end
			3'd1: begin mix_a = apin_q[1]; mix_c = w2_q;   end
			3'd2: begin mix_a = xl_w;      mix_c = dryc_q; end
			3'd3: begin mix_a = apin_q[1]; mix_c = w1_q;   end
			3'd4: begin mix_a = apin_q[0]; mix_c = w2_q;   end
			3'd5: begin mix_a = xr_w;      mix_c = dryc_q; end
			default: begin mix_a = '0;     mix_c = '0;     end
		endcase
	end

	assign term_w = smsr_pkg::qround(PROD_W'(mprod_q));

	always_ff @(posedge clk) begin
		if (in_acc) begin
			xl_q <= left_sample;
			xr_q <= right_sample;
		end
		if (state_q == ST_FEED) begin
			feed_q    <= smsr_pkg::qround(PROD_W'(xl_w + xr_w) *
				PROD_W'(smsr_pkg::C_IN_GAIN));
			acc_q[0]  <= '0;
			acc_q[1]  <= '0;
			vacc_q[0] <= '0;
			vacc_q[1] <= '0;
		end
		if (v_s1) begin
			if ({1'b0, k_s1} >= (KB+1)'(COMB_COUNT)) begin
				acc_q[1] <= acc_q[1] + ACC_W'(comb_rdata);
			end else begin
				acc_q[0] <= acc_q[0] + ACC_W'(comb_rdata);
			end
		end
		if ((state_q == ST_COMB) && comb_last_cyc) begin
			apin_q[0] <= smsr_pkg::sat24(PROD_W'(acc_q[0]));
			apin_q[1] <= smsr_pkg::sat24(PROD_W'(acc_q[1]));
		end else if (state_q == ST_AP_WR) begin
			apin_q[apc_q] <= ap_out;
		end
		if (state_q == ST_MIX) begin
			mprod_q <= 46'(mix_a) * 46'($signed({1'b0, mix_c}));
			if (mix_q != 3'd0) begin
				if (mix_q >= 3'd4) begin
					vacc_q[1] <= vacc_q[1] + VACC_W'(term_w);
				end else begin
					vacc_q[0] <= vacc_q[0] + VACC_W'(term_w);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// An accepted item always starts with the feed step.
	a_accept_feed: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_FEED)
		else $error("accepted item did not enter the feed step");

	// A new result appears only from the final step of an item.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output became valid outside the final step");

	// Comb write-back only happens while the comb phase is running.
	a_comb_wb_phase: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> state_q == ST_COMB)
		else $error("comb write-back outside the comb phase");

endmodule
